### hdl/tpds_pkg.sv
// ---------------------------------------------------------------------------
// tpds_pkg
// Shared types and codes of the triangle pixel depth shader.
// ---------------------------------------------------------------------------
`default_nettype none

package tpds_pkg;

  localparam int unsigned IDX_W = 18;
  localparam logic [7:0] AREA_MIN_RST = 8'd1;

  typedef enum logic [1:0] {
    OP_VERTEX = 2'd0,
    OP_PIXEL  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    OC_WRITTEN    = 3'd0,
    OC_OUTSIDE    = 3'd1,
    OC_DEPTH_FAIL = 3'd2,
    OC_DEGENERATE = 3'd3,
    OC_VERTEX     = 3'd4,
    OC_CLEARED    = 3'd5
  } outc_e;

  typedef enum logic [1:0] {
    K_VERTEX,
    K_PIXEL,
    K_CLEAR,
    K_OUTSIDE
  } kind_e;

  typedef enum logic [1:0] {
    PH_Z,
    PH_U,
    PH_V
  } ph_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISP,
    S_EDGE,
    S_CLASS,
    S_MLOAD,
    S_MRUN,
    S_DSTART,
    S_DWAIT,
    S_OUT
  } st_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         vertex_slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        inv_depth;
    logic signed [23:0] tex_u;
    logic signed [23:0] tex_v;
    logic [8:0]         pixel_x;
    logic [8:0]         pixel_y;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         outcome;
    logic [IDX_W-1:0]   pixel_index;
    logic signed [23:0] out_u;
    logic signed [23:0] out_v;
    logic [31:0]        out_inv_depth;
  } out_word_t;

  typedef struct packed {
    kind_e              kind;
    logic [1:0]         slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        inv_depth;
    logic signed [23:0] tex_u;
    logic signed [23:0] tex_v;
    logic [8:0]         pixel_x;
    logic [8:0]         pixel_y;
    logic [IDX_W-1:0]   pix_idx;
  } task_t;

  typedef struct packed {
    logic start;
    logic wide;
  } div_cmd_t;

endpackage

`default_nettype wire

### hdl/triangle_pixel_depth_shader_core.sv
// ---------------------------------------------------------------------------
// triangle_pixel_depth_shader_core
// Edge-function triangle rasterizer with an inverse-depth store.
// ---------------------------------------------------------------------------
// channel  dir  handshake                  word
// in       in   in_valid_i / in_stall_o    in_word_t
// out      out  out_valid_o / out_stall_i  out_word_t
// cfg      in   cfg_valid_i / cfg_ready_o  area_min, 8 bits
//
// After reset the whole depth store is swept to zero
// with in_stall_o high; cfg writes are taken throughout.
// Vertex, clear and off-screen words go from dispatch straight to the
// output; a pixel rejected as degenerate or outside stops after the edge
// tests, a depth fail after the first divide. A shaded pixel runs through
// the bit-serial multiply-accumulate (36 steps per weight, 24 per
// coordinate) and the one-bit-per-cycle divider (32 then 24 steps, three divides).
// A two-word queue and an output register let either side stall alone.
// ---------------------------------------------------------------------------
`default_nettype none

module triangle_pixel_depth_shader_core import tpds_pkg::*; #(
  parameter int unsigned SCREEN_W = 512,
  parameter int unsigned SCREEN_H = 512
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire in_word_t   in_word_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_word_t       out_word_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i
);

  logic [7:0] area_min_q;
  logic       push, full, pop, head_valid, ready;
  task_t      push_task, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_min_q <= AREA_MIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      area_min_q <= cfg_data_i;
    end
  end

  tpds_front #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .ready_i    (ready),
    .full_i     (full),
    .push_o     (push),
    .task_o     (push_task)
  );

  tpds_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_task),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  tpds_back #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .area_min_i   (area_min_q),
    .ready_o      (ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o)
  );

endmodule

`default_nettype wire

### hdl/tpds_front.sv
// ---------------------------------------------------------------------------
// tpds_front
// Input side: takes words, sorts them by kind and screen bounds, drops words of op 3, queues the rest.
// ---------------------------------------------------------------------------
`default_nettype none

module tpds_front import tpds_pkg::*; #(
  parameter int unsigned SCREEN_W = 512,
  parameter int unsigned SCREEN_H = 512
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_word_t in_word_i,
  input  wire logic     ready_i,
  input  wire logic     full_i,
  output logic          push_o,
  output task_t         task_o
);

  logic        acc;
  logic        on_screen;
  logic [31:0] full_idx;
  logic        started_q;

  // hold off the input until started_q is set after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
    end else begin
      started_q <= 1'b1;
    end
  end

  assign in_stall_o = !started_q || !ready_i || full_i;
  assign acc        = in_valid_i && !in_stall_o;
  assign on_screen  = (32'(in_word_i.pixel_x) < 32'(SCREEN_W)) &&
                      (32'(in_word_i.pixel_y) < 32'(SCREEN_H));
  assign full_idx   = 32'(in_word_i.pixel_y) * 32'(SCREEN_W) + 32'(in_word_i.pixel_x);

  always_comb begin
    task_o.kind      = K_OUTSIDE;
    task_o.slot      = in_word_i.vertex_slot;
    task_o.pos_x     = in_word_i.pos_x;
    task_o.pos_y     = in_word_i.pos_y;
    task_o.inv_depth = in_word_i.inv_depth;
    task_o.tex_u     = in_word_i.tex_u;
    task_o.tex_v     = in_word_i.tex_v;
    task_o.pixel_x   = in_word_i.pixel_x;
    task_o.pixel_y   = in_word_i.pixel_y;
    task_o.pix_idx   = full_idx[IDX_W-1:0];
    push_o           = 1'b0;
    case (in_word_i.op)
      OP_VERTEX: begin
        task_o.kind = K_VERTEX;
        push_o      = acc;
      end
      OP_PIXEL: begin
        task_o.kind = on_screen ? K_PIXEL : K_OUTSIDE;
        push_o      = acc;
      end
      OP_CLEAR: begin
        task_o.kind = on_screen ? K_CLEAR : K_OUTSIDE;
        push_o      = acc;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/tpds_fifo.sv
// ---------------------------------------------------------------------------
// tpds_fifo
// Two-entry queue between the front and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module tpds_fifo import tpds_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire task_t data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output task_t      head_o
);

  localparam int unsigned DEPTH = 2;

  task_t      mem_q [DEPTH];
  logic [0:0] wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'(DEPTH));
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule

`default_nettype wire

### hdl/tpds_div.sv
// ---------------------------------------------------------------------------
// tpds_div
// Restoring shift-subtract divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module tpds_div import tpds_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire div_cmd_t    cmd_i,
  input  wire logic [95:0] num_i,
  input  wire logic [68:0] dvs_i,
  output logic             done_o,
  output logic [31:0]      quot_o
);

  logic [69:0] r_q;
  logic [95:0] n_q;
  logic [68:0] dvs_q;
  logic [31:0] q_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [69:0] r_sh;
  logic        ge;

  assign r_sh   = {r_q[68:0], n_q[95]};
  assign ge     = r_sh >= {1'b0, dvs_q};
  assign done_o = done_q;
  assign quot_o = q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= cmd_i.wide ? 6'd32 : 6'd24;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      r_q   <= cmd_i.wide ? 70'(num_i >> 32) : 70'(num_i >> 24);
      n_q   <= cmd_i.wide ? (num_i << 64) : (num_i << 72);
      dvs_q <= dvs_i;
      q_q   <= '0;
    end else if (busy_q) begin
      r_q <= ge ? (r_sh - {1'b0, dvs_q}) : r_sh;
      n_q <= n_q << 1;
      q_q <= {q_q[30:0], ge};
    end
  end

endmodule

`default_nettype wire

### hdl/tpds_back.sv
// ---------------------------------------------------------------------------
// tpds_back
// Execution side: corners, edge tests, bit-serial MAC, depth store, results.
// ---------------------------------------------------------------------------
`default_nettype none

module tpds_back import tpds_pkg::*; #(
  parameter int unsigned SCREEN_W = 512,
  parameter int unsigned SCREEN_H = 512
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       head_valid_i,
  input  wire task_t      head_i,
  output logic            pop_o,
  input  wire logic [7:0] area_min_i,
  output logic            ready_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_word_t       out_word_o
);

  localparam int unsigned DEPTH  = SCREEN_W * SCREEN_H;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  function automatic logic signed [36:0] edge_fn(input logic signed [16:0] ax, ay,
                                                 bx, by, qx, qy);
    logic signed [17:0] dqx, dqy, dbx, dby;
    dqx = {qx[16], qx} - {ax[16], ax};
    dqy = {qy[16], qy} - {ay[16], ay};
    dbx = {bx[16], bx} - {ax[16], ax};
    dby = {by[16], by} - {ay[16], ay};
    return 37'(dqx) * 37'(dby) - 37'(dqy) * 37'(dbx);
  endfunction

  st_e state_q, state_d;

  logic [ADDR_W-1:0]  clr_q;
  logic signed [15:0] cx_q [3];
  logic signed [15:0] cy_q [3];
  logic [31:0]        cz_q [3];
  logic signed [23:0] cu_q [3];
  logic signed [23:0] cv_q [3];

  task_t              task_q;
  logic [1:0]         ecnt_q;
  logic signed [36:0] area_q;
  logic signed [36:0] e_q [3];
  logic [35:0]        w_q [3];
  logic [66:0]        wz_q [3];
  logic [68:0]        den_q;
  logic [35:0]        a_q;
  logic [1:0]         i_q;
  ph_e                ph_q;
  logic [95:0]        mc_q;
  logic [35:0]        ml_q;
  logic [5:0]         mcnt_q;
  logic               mneg_q;
  logic signed [95:0] acc_q;
  logic               nsgn_q;
  logic [31:0]        inv_q;
  logic [23:0]        u_q, v_q;
  outc_e              oc_q;
  logic               out_valid_q;
  out_word_t          out_q;

  logic [31:0]        depth_mem [DEPTH];
  logic [31:0]        rd_q;
  logic               we;
  logic [ADDR_W-1:0]  waddr, addr;
  logic [31:0]        wdata;
  logic               out_load;

  div_cmd_t           dcmd;
  logic [95:0]        div_num;
  logic [68:0]        div_dvs;
  logic               div_done;
  logic [31:0]        quot;

  logic signed [16:0] ax, ay, bx, by, qx, qy, pxc, pyc;
  logic signed [36:0] edge_val;
  logic [35:0]        area_abs;
  logic               degen, in_tri;
  logic signed [23:0] coord;
  logic [23:0]        cmag;
  logic [95:0]        acc_abs;
  logic [31:0]        idx_full;

  assign idx_full = 32'(task_q.pixel_y) * 32'(SCREEN_W) + 32'(task_q.pixel_x);
  assign addr     = idx_full[ADDR_W-1:0];
  assign ready_o  = (state_q != S_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // edge operands
  assign pxc = {4'b0000, task_q.pixel_x, 4'b1000};
  assign pyc = {4'b0000, task_q.pixel_y, 4'b1000};

  always_comb begin
    ax = {cx_q[0][15], cx_q[0]};
    ay = {cy_q[0][15], cy_q[0]};
    bx = {cx_q[1][15], cx_q[1]};
    by = {cy_q[1][15], cy_q[1]};
    qx = pxc;
    qy = pyc;
    case (ecnt_q)
      2'd0: begin
        qx = {cx_q[2][15], cx_q[2]};
        qy = {cy_q[2][15], cy_q[2]};
      end
      2'd1: begin
        ax = {cx_q[1][15], cx_q[1]};
        ay = {cy_q[1][15], cy_q[1]};
        bx = {cx_q[2][15], cx_q[2]};
        by = {cy_q[2][15], cy_q[2]};
      end
      2'd2: begin
        ax = {cx_q[2][15], cx_q[2]};
        ay = {cy_q[2][15], cy_q[2]};
        bx = {cx_q[0][15], cx_q[0]};
        by = {cy_q[0][15], cy_q[0]};
      end
      default: begin
        qx = pxc;
      end
    endcase
  end

  assign edge_val = edge_fn(ax, ay, bx, by, qx, qy);
  assign area_abs = area_q[36] ? 36'(-area_q) : 36'(area_q);
  assign degen    = (area_abs == 36'd0) || (area_abs < 36'(area_min_i));
  assign in_tri   = (!e_q[0][36] && !e_q[1][36] && !e_q[2][36]) ||
                    ((e_q[0] <= 0) && (e_q[1] <= 0) && (e_q[2] <= 0));

  assign coord   = (ph_q == PH_U) ? cu_q[i_q] : cv_q[i_q];
  assign cmag    = coord[23] ? (~coord + 24'd1) : coord;
  assign acc_abs = acc_q[95] ? 96'(-acc_q) : 96'(acc_q);
  assign div_num = (ph_q == PH_Z) ? 96'(den_q) : acc_abs;
  assign div_dvs = (ph_q == PH_Z) ? 69'(a_q) : den_q;

  tpds_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (dcmd),
    .num_i  (div_num),
    .dvs_i  (div_dvs),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        cx_q[k] <= '0;
        cy_q[k] <= '0;
        cz_q[k] <= '0;
        cu_q[k] <= '0;
        cv_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == S_DISP && task_q.kind == K_VERTEX && task_q.slot != 2'd3) begin
        cx_q[task_q.slot] <= task_q.pos_x;
        cy_q[task_q.slot] <= task_q.pos_y;
        cz_q[task_q.slot] <= task_q.inv_depth;
        cu_q[task_q.slot] <= task_q.tex_u;
        cv_q[task_q.slot] <= task_q.tex_v;
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    we       = 1'b0;
    waddr    = addr;
    wdata    = '0;
    dcmd     = '0;
    out_load = 1'b0;
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        if (clr_q == ADDR_W'(DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (head_valid_i) begin
          pop_o   = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (task_q.kind)
          K_PIXEL: state_d = S_EDGE;
          K_CLEAR: begin
            we      = 1'b1;
            state_d = S_OUT;
          end
          default: state_d = S_OUT;
        endcase
      end
      S_EDGE: begin
        if (ecnt_q == 2'd3) state_d = S_CLASS;
      end
      S_CLASS: begin
        state_d = (degen || !in_tri) ? S_OUT : S_MLOAD;
      end
      S_MLOAD: state_d = S_MRUN;
      S_MRUN: begin
        if (mcnt_q == 6'd0) state_d = (i_q == 2'd2) ? S_DSTART : S_MLOAD;
      end
      S_DSTART: begin
        dcmd.start = 1'b1;
        dcmd.wide  = (ph_q == PH_Z);
        state_d    = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          case (ph_q)
            PH_Z: begin
              if (quot > rd_q) begin
                we      = 1'b1;
                wdata   = quot;
                state_d = S_MLOAD;
              end else begin
                state_d = S_OUT;
              end
            end
            PH_U:    state_d = S_MLOAD;
            default: state_d = S_OUT;
          endcase
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) depth_mem[waddr] <= wdata;
    rd_q <= depth_mem[addr];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (head_valid_i) task_q <= head_i;
        ecnt_q <= 2'd0;
      end
      S_DISP: begin
        inv_q <= '0;
        u_q   <= '0;
        v_q   <= '0;
        case (task_q.kind)
          K_VERTEX: oc_q <= OC_VERTEX;
          K_CLEAR:  oc_q <= OC_CLEARED;
          default:  oc_q <= OC_OUTSIDE;
        endcase
      end
      S_EDGE: begin
        if (ecnt_q == 2'd0) area_q <= edge_val;
        else e_q[2'(ecnt_q - 2'd1)] <= edge_val;
        ecnt_q <= ecnt_q + 2'd1;
      end
      S_CLASS: begin
        oc_q  <= degen ? OC_DEGENERATE : OC_OUTSIDE;
        a_q   <= area_abs;
        i_q   <= 2'd0;
        ph_q  <= PH_Z;
        den_q <= '0;
        for (int k = 0; k < 3; k++) begin
          w_q[k] <= area_q[36] ? 36'(-e_q[k]) : 36'(e_q[k]);
        end
      end
      S_MLOAD: begin
        if (ph_q == PH_Z) begin
          mc_q   <= 96'(cz_q[i_q]);
          ml_q   <= w_q[i_q];
          mcnt_q <= 6'd36;
          mneg_q <= 1'b0;
          acc_q  <= '0;
        end else begin
          mc_q   <= 96'(wz_q[i_q]);
          ml_q   <= 36'(cmag);
          mcnt_q <= 6'd24;
          mneg_q <= coord[23];
          if (i_q == 2'd0) acc_q <= '0;
        end
      end
      S_MRUN: begin
        if (mcnt_q != 6'd0) begin
          if (ml_q[0]) acc_q <= mneg_q ? (acc_q - $signed(mc_q)) : (acc_q + $signed(mc_q));
          mc_q   <= mc_q << 1;
          ml_q   <= ml_q >> 1;
          mcnt_q <= mcnt_q - 6'd1;
        end else begin
          if (ph_q == PH_Z) begin
            wz_q[i_q] <= acc_q[66:0];
            den_q     <= den_q + 69'(acc_q[66:0]);
          end
          i_q <= (i_q == 2'd2) ? 2'd0 : (i_q + 2'd1);
        end
      end
      S_DSTART: begin
        nsgn_q <= acc_q[95] && (ph_q != PH_Z);
      end
      S_DWAIT: begin
        if (div_done) begin
          case (ph_q)
            PH_Z: begin
              if (quot > rd_q) begin
                inv_q <= quot;
                oc_q  <= OC_WRITTEN;
                ph_q  <= PH_U;
              end else begin
                oc_q  <= OC_DEPTH_FAIL;
              end
            end
            PH_U: begin
              u_q  <= nsgn_q ? (~quot[23:0] + 24'd1) : quot[23:0];
              ph_q <= PH_V;
            end
            default: begin
              v_q <= nsgn_q ? (~quot[23:0] + 24'd1) : quot[23:0];
            end
          endcase
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_q.outcome       <= oc_q;
      out_q.pixel_index   <= (task_q.kind == K_VERTEX) ? '0 : task_q.pix_idx;
      out_q.out_u         <= u_q;
      out_q.out_v         <= v_q;
      out_q.out_inv_depth <= inv_q;
    end
  end

endmodule

`default_nettype wire

### test/triangle_pixel_depth_shader_core_tb.sv
// ---------------------------------------------------------------------------
// triangle_pixel_depth_shader_core_tb
// Self-checking bench: drives vertex, pixel and clear words with random
// gaps and output stalls, predicts every result word and compares in order.
// ---------------------------------------------------------------------------
`default_nettype none

module triangle_pixel_depth_shader_core_tb import tpds_pkg::*; ();

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [1:0] SLOT_NONE = 2'd3;
  localparam int unsigned LIMIT = 4000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_word_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [7:0] cfg_data_i = '0;

  triangle_pixel_depth_shader_core i_dut (.*);

  // shading state mirrored in the bench
  logic [7:0] area_min = AREA_MIN_RST;
  logic signed [15:0] cx [3];
  logic signed [15:0] cy [3];
  logic [31:0] cz [3];
  logic signed [23:0] cu [3];
  logic signed [23:0] cv [3];
  logic [31:0] zbuf [int];

  in_word_t pend_q [$];
  out_word_t shade_q [$];
  int send_idle = 0, recv_idle = 0, errors = 0, cycles = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint edge_fn(longint ax, longint ay, longint bx, longint by,
                                     longint qx, longint qy);
    return (qx - ax) * (by - ay) - (qy - ay) * (bx - ax);
  endfunction

  function automatic bit shade(input in_word_t w, output out_word_t r);
    longint vx [3], vy [3], e [3], area, a, px, py, wt;
    logic signed [127:0] wz [3], den, su, sv, q;
    logic [31:0] inv, old;
    int idx;
    r = '0;
    r.outcome = OC_OUTSIDE;
    r.pixel_index = {w.pixel_y, w.pixel_x};
    idx = int'({w.pixel_y, w.pixel_x});
    if (w.op == OP_NONE) return 0;
    if (w.op == OP_VERTEX) begin
      r.outcome = OC_VERTEX;
      r.pixel_index = '0;
      if (w.vertex_slot != SLOT_NONE) begin
        cx[w.vertex_slot] = w.pos_x;
        cy[w.vertex_slot] = w.pos_y;
        cz[w.vertex_slot] = w.inv_depth;
        cu[w.vertex_slot] = w.tex_u;
        cv[w.vertex_slot] = w.tex_v;
      end
      return 1;
    end
    if (w.op == OP_CLEAR) begin
      zbuf[idx] = '0;
      r.outcome = OC_CLEARED;
      return 1;
    end
    for (int i = 0; i < 3; i++) begin
      vx[i] = longint'(cx[i]);
      vy[i] = longint'(cy[i]);
    end
    area = edge_fn(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
    a = area < 0 ? -area : area;
    if (a == 0 || a < area_min) begin
      r.outcome = OC_DEGENERATE;
      return 1;
    end
    px = longint'(w.pixel_x) * 16 + 8;
    py = longint'(w.pixel_y) * 16 + 8;
    e[0] = edge_fn(vx[1], vy[1], vx[2], vy[2], px, py);
    e[1] = edge_fn(vx[2], vy[2], vx[0], vy[0], px, py);
    e[2] = edge_fn(vx[0], vy[0], vx[1], vy[1], px, py);
    if (!((e[0] >= 0 && e[1] >= 0 && e[2] >= 0) || (e[0] <= 0 && e[1] <= 0 && e[2] <= 0)))
      return 1;
    den = '0;
    for (int i = 0; i < 3; i++) begin
      wt = area < 0 ? -e[i] : e[i];
      wz[i] = 128'(wt);
      wz[i] = wz[i] * $signed({1'b0, cz[i]});
      den = den + wz[i];
    end
    q = den / a;
    inv = q[31:0];
    old = zbuf.exists(idx) ? zbuf[idx] : '0;
    if (inv <= old) begin
      r.outcome = OC_DEPTH_FAIL;
      return 1;
    end
    zbuf[idx] = inv;
    su = '0;
    sv = '0;
    for (int i = 0; i < 3; i++) begin
      su = su + wz[i] * cu[i];
      sv = sv + wz[i] * cv[i];
    end
    su = su / den;
    sv = sv / den;
    r.outcome = OC_WRITTEN;
    r.out_u = su[23:0];
    r.out_v = sv[23:0];
    r.out_inv_depth = inv;
    return 1;
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t r;
    bit has;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        has = shade(in_word_i, r);
        if (has) shade_q.push_back(r);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pend_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid_i <= 1'b1;
          in_word_i <= pend_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t x;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (shade_q.size() == 0) begin
          $display("%0t: unexpected word %p", $time, out_word_o);
          errors <= errors + 1;
        end else begin
          x = shade_q.pop_front();
          if (out_word_o !== x) begin
            $display("%0t: mismatch expected %p actual %p", $time, x, out_word_o);
            errors <= errors + 1;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic write_area_min(input logic [7:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    area_min = v;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_word_t mk(int op, int slot, int x, int y,
                                  logic [31:0] z, int u, int v, int pxl, int pyl);
    in_word_t w;
    w.op = 2'(op);
    w.vertex_slot = 2'(slot);
    w.pos_x = 16'(x);
    w.pos_y = 16'(y);
    w.inv_depth = z;
    w.tex_u = 24'(u);
    w.tex_v = 24'(v);
    w.pixel_x = 9'(pxl);
    w.pixel_y = 9'(pyl);
    return w;
  endfunction

  function automatic in_word_t noise();
    logic [159:0] raw;
    in_word_t w;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    return w;
  endfunction

  task automatic fill_random(int n);
    int k, bx, by;
    k = 0;
    while (k < n) begin
      if ($urandom_range(99) < 15) begin
        pend_q.push_back(noise());
        k++;
      end else begin
        bx = $urandom_range(40);
        by = $urandom_range(40);
        for (int s = 0; s < 3; s++)
          pend_q.push_back(mk(OP_VERTEX, s, bx * 16 + $urandom_range(400),
                              by * 16 + $urandom_range(400), $urandom,
                              $urandom, $urandom, $urandom, $urandom));
        k += 3;
        repeat ($urandom_range(3, 8)) begin
          pend_q.push_back(mk($urandom_range(99) < 15 ? OP_CLEAR : OP_PIXEL, $urandom,
                              $urandom, $urandom, $urandom, $urandom, $urandom,
                              bx + $urandom_range(25), by + $urandom_range(25)));
          k++;
        end
      end
    end
  endtask

  task automatic drain();
    while (pend_q.size() > 0 || in_valid_i || shade_q.size() > 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      cx[i] = '0; cy[i] = '0; cz[i] = '0; cu[i] = '0; cv[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero area after reset, extremes, slot 3, op 3, zero depth
    pend_q.push_back(mk(OP_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0));
    pend_q.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 511, 511));
    pend_q.push_back(mk(OP_VERTEX, SLOT_NONE, 32767, 32767, '1, 8388607, 8388607, 0, 0));
    pend_q.push_back(mk(OP_NONE, 0, 0, 0, 0, 0, 0, 3, 3));
    pend_q.push_back(mk(OP_VERTEX, 0, -32768, -32768, '1, -8388608, 8388607, 0, 0));
    pend_q.push_back(mk(OP_VERTEX, 1, 32767, -32768, 0, 8388607, -8388608, 0, 0));
    pend_q.push_back(mk(OP_VERTEX, 2, 0, 32767, 32'h0100_0000, 0, 0, 0, 0));
    pend_q.push_back(mk(OP_PIXEL, 0, 0, 0, 0, 0, 0, 511, 511));
    pend_q.push_back(mk(OP_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0));
    pend_q.push_back(mk(OP_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0));
    pend_q.push_back(mk(OP_VERTEX, 0, 0, 0, 0, 100, 200, 0, 0));
    pend_q.push_back(mk(OP_VERTEX, 1, 320, 0, 0, 300, 400, 0, 0));
    pend_q.push_back(mk(OP_VERTEX, 2, 0, 320, 0, 500, 600, 0, 0));
    pend_q.push_back(mk(OP_PIXEL, 0, 0, 0, 0, 0, 0, 2, 2));
    pend_q.push_back(mk(OP_PIXEL, 0, 0, 0, 0, 0, 0, 30, 30));
    pend_q.push_back(mk(OP_VERTEX, 2, 0, 320, '1, 500, 600, 0, 0));
    pend_q.push_back(mk(OP_PIXEL, 0, 0, 0, 0, 0, 0, 2, 2));
    pend_q.push_back(mk(OP_PIXEL, 0, 0, 0, 0, 0, 0, 2, 2));
    pend_q.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 2, 2));
    pend_q.push_back(mk(OP_PIXEL, 0, 0, 0, 0, 0, 0, 2, 2));
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 27 : ph == 1 ? 62 : 0;
      recv_idle = ph == 0 ? 62 : ph == 1 ? 27 : 0;
      write_area_min(ph == 0 ? 8'd0 : ph == 1 ? 8'd255 : 8'($urandom_range(2, 254)));
      fill_random(130);
      drain();
    end

    if (errors == 0 && shade_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### triangle_pixel_depth_shader_core.f
hdl/tpds_pkg.sv
hdl/tpds_front.sv
hdl/tpds_fifo.sv
hdl/tpds_div.sv
hdl/tpds_back.sv
hdl/triangle_pixel_depth_shader_core.sv
test/triangle_pixel_depth_shader_core_tb.sv
